FILE: rtl/core/ovca_pkg.sv
// Package for the output VC allocator: configuration record, controller states,
// command and status records, and the request, mode and register codes.
// No dependencies; every other file of the block imports it.
`timescale 1ns / 1ps

package ovca_pkg;

    localparam int NUM_VCS   = 32;
    localparam int VC_W      = 5;
    localparam int CAND_W    = 7;
    localparam int RID_W     = 10;
    localparam int COLS_W    = 6;
    localparam int DIV_BITS  = 2;
    localparam int DIV_STEPS = RID_W / DIV_BITS;
    localparam int DIV_CNT_W = 3;
    localparam int VNET_WIN  = 15;
    localparam int PADDR_W   = 5;
    localparam int PDATA_W   = 32;

    localparam logic [1:0] REQ_PROBE  = 2'd0;
    localparam logic [1:0] REQ_ALLOC  = 2'd1;
    localparam logic [1:0] REQ_CREDIT = 2'd2;
    localparam logic [1:0] REQ_SENT   = 2'd3;

    localparam logic [1:0] MODE_NORMAL    = 2'd0;
    localparam logic [1:0] MODE_DRAGONFLY = 2'd1;
    localparam logic [1:0] MODE_FBFLY     = 2'd2;
    localparam logic [1:0] MODE_ESCAPE    = 2'd3;

    localparam logic [1:0] DIR_LOCAL = 2'd0;
    localparam logic [1:0] DIR_INTRA = 2'd1;
    localparam logic [1:0] DIR_INTER = 2'd2;

    localparam logic [2:0] REG_AVOID_MODE   = 3'd0;
    localparam logic [2:0] REG_VCS_PER_VNET = 3'd1;
    localparam logic [2:0] REG_MESH_COLUMNS = 3'd2;
    localparam logic [2:0] REG_OWN_ROUTER   = 3'd3;
    localparam logic [2:0] REG_CREDIT_DEPTH = 3'd4;

    localparam logic [1:0]        AVOID_RESET  = MODE_NORMAL;
    localparam logic [3:0]        VCS_RESET    = 4'd4;
    localparam logic [COLS_W-1:0] COLS_RESET   = 6'd4;
    localparam logic [RID_W-1:0]  OWN_RESET    = 10'd0;
    localparam logic [3:0]        CREDIT_RESET = 4'd4;

    typedef struct packed {
        logic [1:0]        avoid_mode;
        logic [3:0]        vcs_per_vnet;
        logic [COLS_W-1:0] mesh_columns;
        logic [RID_W-1:0]  own_router_id;
        logic [3:0]        credit_depth;
    } t_cfg;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DIV,
        ST_PICK,
        ST_UPDATE,
        ST_COUNT
    } t_state;

    typedef struct packed {
        logic load;
        logic div_step;
        logic pick;
        logic update;
        logic load_out;
    } t_cmd;

    typedef struct packed {
        logic escape;
        logic out_free;
    } t_status;

endpackage

FILE: rtl/core/ovca_regs.sv
// Configuration registers of the output VC allocator behind an APB-style port.
// Depends on ovca_pkg for the register codes and the configuration record.
`timescale 1ns / 1ps

module ovca_regs (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [ovca_pkg::PADDR_W-1:0] paddr,
    input  logic [ovca_pkg::PDATA_W-1:0] pwdata,
    output logic [ovca_pkg::PDATA_W-1:0] prdata,
    output logic                        pready,
    output ovca_pkg::t_cfg              o_cfg
);
    import ovca_pkg::*;

    t_cfg       r_cfg;
    logic       wr_en;
    logic [2:0] reg_idx;

    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite;
    assign reg_idx = paddr[PADDR_W-1:2];
    assign o_cfg   = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.avoid_mode    <= AVOID_RESET;
            r_cfg.vcs_per_vnet  <= VCS_RESET;
            r_cfg.mesh_columns  <= COLS_RESET;
            r_cfg.own_router_id <= OWN_RESET;
            r_cfg.credit_depth  <= CREDIT_RESET;
        end else if (wr_en) begin
            case (reg_idx)
                REG_AVOID_MODE:   r_cfg.avoid_mode    <= pwdata[1:0];
                REG_VCS_PER_VNET: r_cfg.vcs_per_vnet  <= pwdata[3:0];
                REG_MESH_COLUMNS: r_cfg.mesh_columns  <= pwdata[COLS_W-1:0];
                REG_OWN_ROUTER:   r_cfg.own_router_id <= pwdata[RID_W-1:0];
                REG_CREDIT_DEPTH: r_cfg.credit_depth  <= pwdata[3:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        prdata = '0;
        case (reg_idx)
            REG_AVOID_MODE:   prdata = PDATA_W'(r_cfg.avoid_mode);
            REG_VCS_PER_VNET: prdata = PDATA_W'(r_cfg.vcs_per_vnet);
            REG_MESH_COLUMNS: prdata = PDATA_W'(r_cfg.mesh_columns);
            REG_OWN_ROUTER:   prdata = PDATA_W'(r_cfg.own_router_id);
            REG_CREDIT_DEPTH: prdata = PDATA_W'(r_cfg.credit_depth);
            default:          prdata = '0;
        endcase
    end

endmodule

FILE: rtl/core/ovca_ctrl.sv
// Controller of the output VC allocator: sequences load, remainder steps, pick,
// state update and result transfer. Depends on ovca_pkg for states and commands.
`timescale 1ns / 1ps

module ovca_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  ovca_pkg::t_status i_status,
    output ovca_pkg::t_cmd    o_cmd
);
    import ovca_pkg::*;

    localparam logic [DIV_CNT_W-1:0] DIV_LAST = DIV_CNT_W'(DIV_STEPS - 1);

    t_state               r_state, n_state;
    logic [DIV_CNT_W-1:0] r_div_cnt, n_div_cnt;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_div_cnt <= '0;
        end else begin
            r_state   <= n_state;
            r_div_cnt <= n_div_cnt;
        end
    end

    always_comb begin
        n_state    = r_state;
        n_div_cnt  = r_div_cnt;
        o_cmd      = '0;
        o_in_ready = 1'b0;
        case (r_state)
            ST_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_div_cnt  = '0;
                    n_state    = i_status.escape ? ST_DIV : ST_PICK;
                end
            end
            ST_DIV: begin
                o_cmd.div_step = 1'b1;
                if (r_div_cnt == DIV_LAST) begin
                    n_state = ST_PICK;
                end else begin
                    n_div_cnt = r_div_cnt + 1'b1;
                end
            end
            ST_PICK: begin
                o_cmd.pick = 1'b1;
                n_state    = ST_UPDATE;
            end
            ST_UPDATE: begin
                o_cmd.update = 1'b1;
                n_state      = ST_COUNT;
            end
            ST_COUNT: begin
                if (i_status.out_free) begin
                    o_cmd.load_out = 1'b1;
                    n_state        = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

endmodule

FILE: rtl/core/ovca_dp.sv
// Datapath of the output VC allocator: request registers, column remainders,
// VC selection, active flags, credit counts and the result register.
// Depends on ovca_pkg for codes, widths and the command and status records.
`timescale 1ns / 1ps

module ovca_dp (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  ovca_pkg::t_cfg              i_cfg,
    input  ovca_pkg::t_cmd              i_cmd,
    output ovca_pkg::t_status           o_status,
    input  logic [1:0]                  i_req_type,
    input  logic [1:0]                  i_vnet,
    input  logic [4:0]                  i_in_vc,
    input  logic [1:0]                  i_out_dir,
    input  logic [3:0]                  i_hops_traversed,
    input  logic [ovca_pkg::RID_W-1:0]  i_dest_router,
    input  logic [4:0]                  i_target_vc,
    input  logic                        i_free_signal,
    input  logic                        i_out_ready,
    output logic                        o_out_valid,
    output logic                        o_vc_found,
    output logic [4:0]                  o_vc_index,
    output logic                        o_vc_has_credit,
    output logic [3:0]                  o_active_in_vnet
);
    import ovca_pkg::*;

    function automatic logic [COLS_W-1:0] rem_step(input logic [COLS_W-1:0] rem,
                                                   input logic bit_in,
                                                   input logic [COLS_W-1:0] cols);
        logic [COLS_W:0] t;
        t = {rem, bit_in};
        if (t >= {1'b0, cols}) begin
            t = t - {1'b0, cols};
        end
        return t[COLS_W-1:0];
    endfunction

    logic [1:0]        r_req, r_vnet, r_dir;
    logic [4:0]        r_in_vc, r_tvc;
    logic [3:0]        r_hops;
    logic              r_free;
    logic [RID_W-1:0]  r_sh_d, r_sh_o;
    logic [COLS_W-1:0] r_rem_d, r_rem_o;
    logic              r_found;
    logic [VC_W-1:0]   r_index;
    logic [NUM_VCS-1:0] r_active;
    logic [3:0]        r_credit [NUM_VCS];
    logic              r_out_valid, r_out_found, r_out_credit;
    logic [VC_W-1:0]   r_out_index;
    logic [3:0]        r_out_count;

    logic [COLS_W-1:0]  cols;
    logic               west_eff;
    logic [CAND_W-1:0]  base, limit, fixed_vc;
    logic               use_fixed, chk_limit, fixed_ok;
    logic [NUM_VCS-1:0] in_win, free_vec;
    logic [VC_W-1:0]    first_idx;
    logic               pick_found;
    logic [VC_W-1:0]    pick_index;
    logic [3:0]         tvc_credit;
    logic [NUM_VCS-1:0] shifted;
    logic [VNET_WIN-1:0] win_mask;
    logic [3:0]         active_cnt;

    assign cols     = (i_cfg.mesh_columns == '0) ? COLS_W'(1) : i_cfg.mesh_columns;
    assign west_eff = (i_cfg.avoid_mode == MODE_ESCAPE) && (r_rem_d < r_rem_o);
    assign base     = CAND_W'(r_vnet) * CAND_W'(i_cfg.vcs_per_vnet);
    assign limit    = base + CAND_W'(i_cfg.vcs_per_vnet);

    always_comb begin
        for (int v = 0; v < NUM_VCS; v++) begin
            in_win[v] = (CAND_W'(v) >= base) &&
                        ((CAND_W'(v) + CAND_W'(west_eff)) < limit);
        end
        free_vec  = ~r_active & in_win;
        first_idx = '0;
        for (int v = NUM_VCS - 1; v >= 0; v--) begin
            if (free_vec[v]) begin
                first_idx = VC_W'(v);
            end
        end
    end

    always_comb begin
        use_fixed = 1'b0;
        chk_limit = 1'b0;
        fixed_vc  = '0;
        case (i_cfg.avoid_mode)
            MODE_DRAGONFLY: begin
                if (r_dir >= DIR_INTER) begin
                    use_fixed = 1'b1;
                    chk_limit = 1'b1;
                    fixed_vc  = (r_hops == '0) ? base + CAND_W'(1)
                                               : CAND_W'(r_in_vc) + CAND_W'(1);
                end else if (r_dir == DIR_INTRA) begin
                    use_fixed = 1'b1;
                    fixed_vc  = (r_hops == '0) ? base : CAND_W'(r_in_vc);
                end
            end
            MODE_FBFLY: begin
                if (r_dir != DIR_LOCAL) begin
                    use_fixed = 1'b1;
                    chk_limit = 1'b1;
                    fixed_vc  = base + CAND_W'(r_hops);
                end
            end
            default: ;
        endcase
    end

    assign fixed_ok   = (fixed_vc < CAND_W'(NUM_VCS)) && !(chk_limit && (fixed_vc >= limit))
                        && !r_active[fixed_vc[VC_W-1:0]];
    assign pick_found = use_fixed ? fixed_ok : (|free_vec);
    assign pick_index = use_fixed ? fixed_vc[VC_W-1:0] : first_idx;
    assign tvc_credit = r_credit[r_tvc];

    always_comb begin
        for (int j = 0; j < VNET_WIN; j++) begin
            win_mask[j] = (4'(j) < i_cfg.vcs_per_vnet);
        end
        shifted    = r_active >> base;
        active_cnt = 4'($countones(shifted[VNET_WIN-1:0] & win_mask));
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_req   <= i_req_type;
            r_vnet  <= i_vnet;
            r_in_vc <= i_in_vc;
            r_dir   <= i_out_dir;
            r_hops  <= i_hops_traversed;
            r_tvc   <= i_target_vc;
            r_free  <= i_free_signal;
            r_sh_d  <= i_dest_router;
            r_sh_o  <= i_cfg.own_router_id;
            r_rem_d <= '0;
            r_rem_o <= '0;
        end else if (i_cmd.div_step) begin
            r_sh_d  <= r_sh_d << DIV_BITS;
            r_sh_o  <= r_sh_o << DIV_BITS;
            r_rem_d <= rem_step(rem_step(r_rem_d, r_sh_d[RID_W-1], cols),
                                r_sh_d[RID_W-2], cols);
            r_rem_o <= rem_step(rem_step(r_rem_o, r_sh_o[RID_W-1], cols),
                                r_sh_o[RID_W-2], cols);
        end
        if (i_cmd.pick) begin
            r_found <= pick_found;
            r_index <= pick_found ? pick_index : '0;
        end
        if (i_cmd.load_out) begin
            r_out_found  <= r_found && (r_req == REQ_PROBE || r_req == REQ_ALLOC);
            r_out_index  <= (r_req == REQ_PROBE || r_req == REQ_ALLOC) ? r_index : '0;
            r_out_credit <= (tvc_credit != '0);
            r_out_count  <= active_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active <= '0;
            for (int v = 0; v < NUM_VCS; v++) begin
                r_credit[v] <= CREDIT_RESET;
            end
        end else if (i_cmd.update) begin
            case (r_req)
                REQ_ALLOC: begin
                    if (r_found) begin
                        r_active[r_index] <= 1'b1;
                    end
                end
                REQ_CREDIT: begin
                    if (tvc_credit < i_cfg.credit_depth) begin
                        r_credit[r_tvc] <= tvc_credit + 4'd1;
                    end
                    if (r_free) begin
                        r_active[r_tvc] <= 1'b0;
                    end
                end
                REQ_SENT: begin
                    if (tvc_credit != '0) begin
                        r_credit[r_tvc] <= tvc_credit - 4'd1;
                    end
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.load_out) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    assign o_status.escape   = (i_cfg.avoid_mode == MODE_ESCAPE);
    assign o_status.out_free = !r_out_valid || i_out_ready;

    assign o_out_valid      = r_out_valid;
    assign o_vc_found       = r_out_found;
    assign o_vc_index       = r_out_index;
    assign o_vc_has_credit  = r_out_credit;
    assign o_active_in_vnet = r_out_count;

endmodule

FILE: rtl/core/noc_output_vc_allocator_top.sv
// Top level of the output VC allocator over ovca_pkg, ovca_regs, ovca_ctrl and ovca_dp.
// A result reaches the output register through the pick, update and count states that
// follow its input transfer; in escape mode the remainder steps, two bits each, come first.
// One item is in work at a time: a new transfer is taken only once the last result is loaded,
// and a result left waiting holds the next item in its final step.
// Synchronous active-low reset idles all VCs, sets credits to four and loads defaults.
`timescale 1ns / 1ps

module noc_output_vc_allocator_top (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [ovca_pkg::PADDR_W-1:0] paddr,
    input  logic [ovca_pkg::PDATA_W-1:0] pwdata,
    output logic [ovca_pkg::PDATA_W-1:0] prdata,
    output logic                         pready,
    input  logic                         i_in_valid,
    output logic                         o_in_ready,
    input  logic [1:0]                   i_req_type,
    input  logic [1:0]                   i_vnet,
    input  logic [4:0]                   i_in_vc,
    input  logic [1:0]                   i_out_dir,
    input  logic [3:0]                   i_hops_traversed,
    input  logic [9:0]                   i_dest_router,
    input  logic [4:0]                   i_target_vc,
    input  logic                         i_free_signal,
    output logic                         o_out_valid,
    input  logic                         i_out_ready,
    output logic                         o_vc_found,
    output logic [4:0]                   o_vc_index,
    output logic                         o_vc_has_credit,
    output logic [3:0]                   o_active_in_vnet
);
    import ovca_pkg::*;

    t_cfg    cfg;
    t_cmd    cmd;
    t_status status;

    ovca_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    ovca_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_status   (status),
        .o_cmd      (cmd)
    );

    ovca_dp u_dp (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg            (cfg),
        .i_cmd            (cmd),
        .o_status         (status),
        .i_req_type       (i_req_type),
        .i_vnet           (i_vnet),
        .i_in_vc          (i_in_vc),
        .i_out_dir        (i_out_dir),
        .i_hops_traversed (i_hops_traversed),
        .i_dest_router    (i_dest_router),
        .i_target_vc      (i_target_vc),
        .i_free_signal    (i_free_signal),
        .i_out_ready      (i_out_ready),
        .o_out_valid      (o_out_valid),
        .o_vc_found       (o_vc_found),
        .o_vc_index       (o_vc_index),
        .o_vc_has_credit  (o_vc_has_credit),
        .o_active_in_vnet (o_active_in_vnet)
    );

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> !o_in_ready)
        else $error("Input accepted again straight after a transfer.");

    a_index_zero_when_missed: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_vc_found) |-> (o_vc_index == '0))
        else $error("VC index is nonzero on a result that found no VC.");

    a_one_load_per_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.load_out |=> o_out_valid)
        else $error("Result register did not present a loaded result.");

    a_count_in_vnet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.load_out |=> (o_active_in_vnet <= cfg.vcs_per_vnet))
        else $error("Active count exceeds the VCs of one virtual network.");

endmodule
